@@ src/ipr_pkg.sv @@
// ipr_pkg: shared types and constants of the isolated pixel remover
// no dependencies; used by the interfaces and all modules but ipr_ram

package ipr_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int WIN_W     = 9;
  localparam int LINE_W    = PIX_W + 1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0] BLACK = 8'd0;
  localparam logic [PIX_W-1:0] WHITE = 8'd255;

  localparam int CENTER_BIT = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_LVL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [WIN_W-1:0] window;
    logic             interior;
    logic             last;
  } ipr_job_t;

endpackage

@@ src/ipr_intf.sv @@
// ipr_intf: valid/ready channel interfaces of the isolated pixel remover
// depends on ipr_pkg for payload widths

interface ipr_in_if import ipr_pkg::*;;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output req_type, output pixel, input ready);
  modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

interface ipr_out_if import ipr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             removed;
  logic             frame_last;

  modport source (output valid, output out_pixel, output removed, output frame_last,
                  input ready);
  modport sink   (input valid, input out_pixel, input removed, input frame_last,
                  output ready);
endinterface

interface ipr_cfg_if import ipr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/ipr_ram.sv @@
// ipr_ram: generic single-write, single-read memory with registered read data
// no dependencies

module ipr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ipr_fifo.sv @@
// ipr_fifo: short job queue between the front and back parts
// depends on ipr_pkg for the job type and queue depth

module ipr_fifo import ipr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ipr_job_t           push_job,
  input  logic               pop,
  output logic               q_valid,
  output ipr_job_t           q_job,
  output logic [Q_LVL_W-1:0] level
);

  ipr_job_t           slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [Q_LVL_W-1:0] count_r, count_nxt;
  logic               do_pop;

  assign q_valid = count_r != '0;
  assign q_job   = slots[rptr_r];
  assign level   = count_r;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr_r] <= push_job;
    end
  end

endmodule

@@ src/ipr_front.sv @@
// ipr_front: accepts beats, tracks frame position, runs the line store and
// the 3x3 black window, and pushes output jobs; depends on ipr_pkg, ipr_intf

module ipr_front import ipr_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ipr_in_if.sink                       in_bus,
  ipr_cfg_if.sink                      cfg_bus,
  output logic                         ram_we,
  output logic [$clog2(MAX_WIDTH)-1:0] ram_waddr,
  output logic [LINE_W-1:0]            ram_wdata,
  output logic [$clog2(MAX_WIDTH)-1:0] ram_raddr,
  input  logic [LINE_W-1:0]            ram_rdata,
  input  logic [Q_LVL_W-1:0]           q_level,
  output logic                         job_valid,
  output ipr_job_t                     job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  function automatic logic [31:0] clamp_last(input logic [CFG_W-1:0] v, input int unsigned lim);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) return 32'd0;
    if (v32 > lim) return 32'(lim - 1);
    return v32 - 32'd1;
  endfunction

  logic [CW-1:0] w_last_r;
  logic [RW-1:0] h_last_r;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic          done_r, done_nxt;

  logic              s1_valid_r;
  logic              s1_pix_mode_r;
  logic              s1_emit_r;
  logic              s1_use_ram_r;
  logic              s1_interior_r;
  logic              s1_last_r;
  logic [CW-1:0]     s1_addr_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic              s1_fwd_r;
  logic [LINE_W-1:0] s1_fwd_data_r;

  logic [WIN_W-1:0] window_r, window_nxt;
  logic [PIX_W-1:0] center_r;

  logic             in_fire, cfg_fire, cfg_restart, is_drain, take_pix, take_drn;
  logic             lag_met, out_h_last, out_w_last, emit, frame_end, interior;
  logic [LINE_W-1:0] rd;
  logic [PIX_W-1:0] midv;

  assign cfg_bus.ready = 1'b1;
  assign cfg_fire      = cfg_bus.valid;
  assign cfg_restart   = cfg_fire && (cfg_bus.index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});

  assign in_bus.ready = ((Q_LVL_W + 1)'(q_level) + (Q_LVL_W + 1)'(s1_valid_r))
                        < (Q_LVL_W + 1)'(QUEUE_DEPTH);
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign is_drain = in_bus.req_type == REQ_DRAIN;
  assign take_pix = in_fire && !is_drain && !done_r;
  assign take_drn = in_fire && is_drain && done_r;

  assign lag_met    = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
  assign out_h_last = out_row_r == h_last_r;
  assign out_w_last = out_col_r == w_last_r;
  assign emit       = take_drn || (take_pix && lag_met);
  assign frame_end  = emit && out_h_last && out_w_last;
  assign interior   = (out_row_r != '0) && !out_h_last && (out_col_r != '0) && !out_w_last;

  assign ram_raddr = is_drain ? out_col_r : in_col_r;

  // position counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    done_nxt    = done_r;
    if (take_pix) begin
      if (in_col_r == w_last_r) begin
        in_col_nxt = '0;
        if (in_row_r == h_last_r) begin
          in_row_nxt = '0;
          done_nxt   = 1'b1;
        end else begin
          in_row_nxt = in_row_r + 1'b1;
        end
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end
    if (emit) begin
      if (out_w_last) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end
    if (frame_end || cfg_restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      done_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r   <= CW'(clamp_last(CFG_W'(RESET_WIDTH), MAX_WIDTH));
      h_last_r   <= RW'(clamp_last(CFG_W'(RESET_HEIGHT), MAX_HEIGHT));
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      done_r     <= 1'b0;
      s1_valid_r <= 1'b0;
      window_r   <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      done_r     <= done_nxt;
      s1_valid_r <= take_pix || take_drn;
      if (ram_we) begin
        window_r <= window_nxt;
      end
      if (cfg_fire) begin
        case (cfg_bus.index)
          REG_IMAGE_WIDTH: begin
            w_last_r <= CW'(clamp_last(cfg_bus.data, MAX_WIDTH));
          end
          REG_IMAGE_HEIGHT: begin
            h_last_r <= RW'(clamp_last(cfg_bus.data, MAX_HEIGHT));
          end
          default: begin
          end
        endcase
      end
    end
  end

  // second stage payload
  always_ff @(posedge clk) begin
    s1_pix_mode_r <= take_pix;
    s1_emit_r     <= emit;
    s1_use_ram_r  <= take_drn && out_h_last;
    s1_interior_r <= take_pix && interior;
    s1_last_r     <= frame_end;
    s1_addr_r     <= ram_raddr;
    s1_pix_r      <= in_bus.pixel;
    s1_fwd_r      <= ram_we && (ram_waddr == ram_raddr);
    s1_fwd_data_r <= ram_wdata;
    if (ram_we) begin
      center_r <= midv;
    end
  end

  assign rd         = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign midv       = rd[PIX_W-1:0];
  assign ram_we     = s1_valid_r && s1_pix_mode_r;
  assign ram_waddr  = s1_addr_r;
  assign ram_wdata  = {midv == BLACK, s1_pix_r};
  assign window_nxt = {window_r[WIN_W-4:0], s1_pix_r == BLACK, midv == BLACK, rd[LINE_W-1]};

  assign job_valid    = s1_valid_r && s1_emit_r;
  assign job.value    = s1_use_ram_r ? midv : center_r;
  assign job.window   = window_nxt;
  assign job.interior = s1_interior_r;
  assign job.last     = s1_last_r;

endmodule

@@ src/ipr_back.sv @@
// ipr_back: takes jobs from the queue, decides removal and holds the result beat
// depends on ipr_pkg, ipr_intf

module ipr_back import ipr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  ipr_job_t  q_job,
  output logic      q_pop,
  ipr_out_if.source out_bus
);

  logic             out_valid_r;
  logic [PIX_W-1:0] pixel_r;
  logic             removed_r;
  logic             last_r;
  logic [7:0]       nbr;
  logic             isolated;

  // neighbors without the center, at most one black
  assign nbr      = {q_job.window[WIN_W-1:CENTER_BIT+1], q_job.window[CENTER_BIT-1:0]};
  assign isolated = q_job.interior && q_job.window[CENTER_BIT] && ((nbr & (nbr - 8'd1)) == 8'd0);
  assign q_pop    = q_valid && (!out_valid_r || out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pixel_r   <= isolated ? WHITE : q_job.value;
      removed_r <= isolated;
      last_r    <= q_job.last;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_pixel  = pixel_r;
  assign out_bus.removed    = removed_r;
  assign out_bus.frame_last = last_r;

endmodule

@@ src/isolated_pixel_remover.sv @@
// isolated_pixel_remover: top level, front part, line store, job queue, back part
// depends on ipr_pkg, ipr_intf, ipr_ram, ipr_fifo, ipr_front, ipr_back
//
//   channel   dir  handshake      payload
//   in_bus    in   valid/ready    req_type, pixel
//   out_bus   out  valid/ready    out_pixel, removed, frame_last
//   cfg_bus   in   valid/ready    index, data (ready always high)
//
// one beat per cycle in both directions while the queue has room and the output is taken
// rate is set by the line store, one read and one write port per cycle
// synchronous active-low reset; the line store is not cleared and needs no pass
// a stalled output holds in the output register while the queue keeps taking jobs until full

module isolated_pixel_remover import ipr_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  ipr_in_if.sink    in_bus,
  ipr_out_if.source out_bus,
  ipr_cfg_if.sink   cfg_bus
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic               ram_we;
  logic [CW-1:0]      ram_waddr;
  logic [LINE_W-1:0]  ram_wdata;
  logic [CW-1:0]      ram_raddr;
  logic [LINE_W-1:0]  ram_rdata;
  logic [Q_LVL_W-1:0] q_level;
  logic               job_valid;
  ipr_job_t           job;
  logic               q_valid;
  ipr_job_t           q_job;
  logic               q_pop;

  ipr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg_bus   (cfg_bus),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .q_level   (q_level),
    .job_valid (job_valid),
    .job       (job)
  );

  ipr_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ipr_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (job),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .level    (q_level)
  );

  ipr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

@@ src/ipr_checker.sv @@
// ipr_checker: port-level assertions for isolated_pixel_remover, bound to the top
// depends on ipr_pkg

module ipr_checker import ipr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel,
  input logic             removed,
  input logic             frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel) && $stable(removed) && $stable(frame_last))
    else $error("result payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_removed_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && removed |-> out_pixel == WHITE)
    else $error("removed pixel not white");

  a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_last |-> !removed)
    else $error("last pixel of frame flagged as removed");

endmodule

bind isolated_pixel_remover ipr_checker u_ipr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_pixel  (out_bus.out_pixel),
  .removed    (out_bus.removed),
  .frame_last (out_bus.frame_last)
);

@@ sim/isolated_pixel_checker.sv @@
`timescale 1ns / 1ps
// isolated_pixel_checker: watches the pixel, result and register channels of the
// isolated pixel remover, predicts every cleaned pixel and compares each result beat
// depends on ipr_pkg and the channel interfaces of ipr_intf

module isolated_pixel_checker import ipr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ipr_in_if    in_bus,
  ipr_out_if   out_bus,
  ipr_cfg_if   cfg_bus,
  output int   error_count,
  output int   pending_count,
  output int   result_count,
  output int   removal_count,
  output int   frame_count
);

  localparam logic [WIN_W-1:0] CENTER_MASK = WIN_W'(1) << CENTER_BIT;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             removed;
    logic             last;
  } cleaned_px_t;

  cleaned_px_t      pending_px[$];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             upper_black[DEF_MAX_WIDTH];
  logic [PIX_W-1:0] middle_value[DEF_MAX_WIDTH];
  logic [WIN_W-1:0] black_win;
  logic [PIX_W-1:0] center_px;
  logic             frame_in_done;
  int               col;
  int               row;
  int               out_pos;

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int max_dim);
    if (v == '0) return 1;
    if (int'(v) > max_dim) return max_dim;
    return int'(v);
  endfunction

  task automatic restart_frame();
    col           = 0;
    row           = 0;
    out_pos       = 0;
    black_win     = '0;
    frame_in_done = 1'b0;
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = data;
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data;
        restart_frame();
      end
      default: ;
    endcase
  endtask

  task automatic take_beat(logic req, logic [PIX_W-1:0] pix);
    int               w;
    int               h;
    int               total;
    int               r;
    int               c;
    logic             top_blk;
    logic [PIX_W-1:0] mid;
    logic             emitted;
    cleaned_px_t      px;
    w       = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h       = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    total   = w * h;
    emitted = 1'b0;
    px      = '0;
    if (req == REQ_PIXEL) begin
      if (frame_in_done || col >= w || row >= h) return;
      top_blk           = upper_black[col];
      mid               = middle_value[col];
      black_win         = {black_win[WIN_W-4:0], pix == BLACK, mid == BLACK, top_blk};
      upper_black[col]  = (mid == BLACK);
      middle_value[col] = pix;
      if (row * w + col >= w + 1 && out_pos < total) begin
        r        = out_pos / w;
        c        = out_pos % w;
        px.value = center_px;
        if (r >= 1 && r + 1 < h && c >= 1 && c + 1 < w && black_win[CENTER_BIT]
            && $countones(black_win & ~CENTER_MASK) <= 1) begin
          px.value   = WHITE;
          px.removed = 1'b1;
        end
        px.last = (out_pos + 1 == total);
        pending_px.push_back(px);
        out_pos++;
        emitted = 1'b1;
      end
      center_px = mid;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) begin
          row           = 0;
          frame_in_done = 1'b1;
        end
      end
      if (emitted && px.last) restart_frame();
    end else if (frame_in_done && out_pos < total) begin
      r        = out_pos / w;
      c        = out_pos % w;
      px.value = (r + 1 == h) ? middle_value[c] : center_px;
      px.last  = (out_pos + 1 == total);
      pending_px.push_back(px);
      out_pos++;
      if (px.last) restart_frame();
    end
  endtask

  task automatic check_result();
    cleaned_px_t want;
    if (pending_px.size() == 0) begin
      error_count++;
      $error("result beat with no pixel pending: out_pixel %0d removed %0b frame_last %0b",
             out_bus.out_pixel, out_bus.removed, out_bus.frame_last);
      return;
    end
    want = pending_px.pop_front();
    if (out_bus.out_pixel !== want.value) begin
      error_count++;
      $error("out_pixel mismatch: expected %0d, actual %0d", want.value, out_bus.out_pixel);
    end
    if (out_bus.removed !== want.removed) begin
      error_count++;
      $error("removed mismatch: expected %0b, actual %0b", want.removed, out_bus.removed);
    end
    if (out_bus.frame_last !== want.last) begin
      error_count++;
      $error("frame_last mismatch: expected %0b, actual %0b", want.last, out_bus.frame_last);
    end
    result_count++;
    if (want.removed) removal_count++;
    if (want.last) frame_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = CFG_W'(RESET_WIDTH);
      height_reg = CFG_W'(RESET_HEIGHT);
      for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
        upper_black[i]  = 1'b0;
        middle_value[i] = BLACK;
      end
      center_px = BLACK;
      restart_frame();
      pending_px.delete();
      error_count   = 0;
      result_count  = 0;
      removal_count = 0;
      frame_count   = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_result();
      if (cfg_bus.valid && cfg_bus.ready) apply_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) take_beat(in_bus.req_type, in_bus.pixel);
    end
    pending_count = pending_px.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// testbench: clock, reset, frame stimulus and verdict for the isolated pixel remover
// depends on ipr_pkg, ipr_intf, isolated_pixel_remover and isolated_pixel_checker

module testbench;
  import ipr_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_BEATS  = 900;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_cycles;
  int   beats_sent;
  int   settings_used;
  int   frame_w;
  int   frame_h;
  int   error_count;
  int   pending_count;
  int   result_count;
  int   removal_count;
  int   frame_count;

  logic [PIX_W-1:0] dot_frame[9]  = '{8'd255, 8'd1, 8'd254, 8'd128, BLACK, WHITE,
                                      8'd1, WHITE, BLACK};
  logic [PIX_W-1:0] pair_frame[9] = '{BLACK, BLACK, WHITE, WHITE, BLACK, WHITE,
                                      WHITE, WHITE, WHITE};

  ipr_in_if  in_bus();
  ipr_out_if out_bus();
  ipr_cfg_if cfg_bus();

  isolated_pixel_remover u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  isolated_pixel_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_bus        (in_bus),
    .out_bus       (out_bus),
    .cfg_bus       (cfg_bus),
    .error_count   (error_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .removal_count (removal_count),
    .frame_count   (frame_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("run stalled after %0d input beats and %0d results, %0d still pending",
                 beats_sent, result_count, pending_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int eff_dim(logic [CFG_W-1:0] v, int max_dim);
    if (v == '0) return 1;
    if (int'(v) > max_dim) return max_dim;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(int black_pct);
    if ($urandom_range(99) < black_pct) return BLACK;
    case ($urandom_range(7))
      0: return WHITE;
      1: return 8'd1;
      default: return PIX_W'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_beat(logic req, logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= req;
    in_bus.pixel    <= pix;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] w_reg, logic [CFG_W-1:0] h_reg, bit width_only);
    if (width_only) begin
      write_reg(REG_IMAGE_WIDTH, w_reg);
    end else if ($urandom_range(1) == 1) begin
      write_reg(REG_IMAGE_WIDTH, w_reg);
      write_reg(REG_IMAGE_HEIGHT, h_reg);
    end else begin
      write_reg(REG_IMAGE_HEIGHT, h_reg);
      write_reg(REG_IMAGE_WIDTH, w_reg);
    end
    if ($urandom_range(7) == 0)
      write_reg(($urandom_range(1) == 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
    frame_w = eff_dim(w_reg, DEF_MAX_WIDTH);
    if (!width_only) frame_h = eff_dim(h_reg, DEF_MAX_HEIGHT);
    settings_used++;
  endtask

  // cut below the frame size leaves the frame unfinished
  task automatic send_frame(int black_pct, int cut);
    int total;
    int drains;
    int hold_at;
    int noise_pct;
    total     = frame_w * frame_h;
    noise_pct = ($urandom_range(3) == 0) ? 10 : 0;
    hold_at   = ($urandom_range(9) == 0) ? int'($urandom_range(cut)) : -1;
    for (int i = 0; i < cut; i++) begin
      if (i == hold_at) wait_quiet();
      if ($urandom_range(99) < noise_pct) send_beat(REQ_DRAIN, PIX_W'($urandom));
      send_beat(REQ_PIXEL, pick_pixel(black_pct));
    end
    if (cut < total) return;
    drains = (total < frame_w + 1) ? total : frame_w + 1;
    for (int j = 0; j < drains; j++) begin
      if ($urandom_range(99) < noise_pct) send_beat(REQ_PIXEL, PIX_W'($urandom));
      send_beat(REQ_DRAIN, PIX_W'($urandom));
    end
  endtask

  function automatic int pick_density();
    case ($urandom_range(3))
      0: return 3;
      1: return 15;
      2: return 40;
      default: return 85;
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] w_reg;
    logic [CFG_W-1:0] h_reg;
    int               cut;
    int               frames;
    int               beats_random;
    int               beats_before;
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.req_type = REQ_PIXEL;
    in_bus.pixel    = BLACK;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = REG_IMAGE_WIDTH;
    cfg_bus.data    = '0;
    out_bus.ready   = 1'b0;
    idle_pct        = 35;
    stall_cycles    = 0;
    beats_sent      = 0;
    settings_used   = 0;
    frame_w         = RESET_WIDTH;
    frame_h         = RESET_HEIGHT;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // lone dot with one black corner, then a dot with two black neighbors
    set_size(CFG_W'(3), CFG_W'(3), 1'b0);
    send_beat(REQ_DRAIN, WHITE);
    foreach (dot_frame[i]) send_beat(REQ_PIXEL, dot_frame[i]);
    send_beat(REQ_PIXEL, BLACK);
    repeat (4) send_beat(REQ_DRAIN, BLACK);
    send_beat(REQ_DRAIN, WHITE);
    foreach (pair_frame[i]) send_beat(REQ_PIXEL, pair_frame[i]);
    repeat (4) send_beat(REQ_DRAIN, WHITE);
    wait_quiet();

    // size extremes, zero and saturated register values
    set_size('0, '0, 1'b0);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '0);
    send_frame(50, 1);
    wait_quiet();
    set_size('1, CFG_W'(1), 1'b0);
    send_frame(15, 40);
    wait_quiet();
    set_size(CFG_W'(1), '1, 1'b0);
    send_frame(40, 60);
    wait_quiet();
    idle_pct = 0;
    set_size(CFG_W'(64), CFG_W'(3), 1'b0);
    send_frame(5, frame_w * frame_h);
    wait_quiet();
    idle_pct = 35;

    beats_random = 0;
    while (beats_random < RANDOM_BEATS) begin
      wait_quiet();
      case ($urandom_range(9))
        0: w_reg = CFG_W'($urandom_range(1, 2));
        1, 2, 3, 4, 5, 6: w_reg = CFG_W'($urandom_range(3, 10));
        7, 8: w_reg = CFG_W'($urandom_range(11, 24));
        default: w_reg = CFG_W'($urandom_range(25, 64));
      endcase
      if ($urandom_range(4) == 0)
        h_reg = CFG_W'($urandom_range(1, 2));
      else
        h_reg = CFG_W'($urandom_range(3, 8));
      set_size(w_reg, h_reg, $urandom_range(4) == 0);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        beats_before = beats_sent;
        cut = frame_w * frame_h;
        if ($urandom_range(9) == 0) cut = $urandom_range(cut - 1);
        send_frame(pick_density(), cut);
        beats_random += beats_sent - beats_before;
        if (cut < frame_w * frame_h) break;
      end
    end

    wait_quiet();
    $display("run covered %0d frames over %0d size settings, %0d input beats, %0d results",
             frame_count, settings_used, beats_sent, result_count);
    $display("isolated black pixels whitened: %0d, field mismatches: %0d",
             removal_count, error_count);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
